FILE: src/qra_pkg.sv
`timescale 1ns / 1ps
package qra_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 16;
    localparam int LIMIT_W       = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd1;
    // Sum of four 16x16 products needs 34 signed bits
    localparam int ACC_W = 34;
    // |prod| << FRAC_BITS never exceeds 2^32
    localparam int NUM_W = 33;
    localparam int CNT_W = 6;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MAC,
        OP_SQR,
        OP_ROOT,
        OP_DECIDE,
        OP_DLOAD,
        OP_DSTEP,
        OP_DSTORE,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic degen;
    } dp_stat_t;

    typedef struct packed {
        logic [1:0] ai;
        logic [1:0] bi;
        logic       neg;
    } term_t;

    // Hamilton product terms a*b; step[3:2] = component (x,y,z,w), step[1:0] = term
    function automatic term_t term_sel(input logic [3:0] step);
        term_t t;
        unique case (step)
            4'd0:  t = '{2'd3, 2'd0, 1'b0};
            4'd1:  t = '{2'd0, 2'd3, 1'b0};
            4'd2:  t = '{2'd1, 2'd2, 1'b0};
            4'd3:  t = '{2'd2, 2'd1, 1'b1};
            4'd4:  t = '{2'd3, 2'd1, 1'b0};
            4'd5:  t = '{2'd1, 2'd3, 1'b0};
            4'd6:  t = '{2'd2, 2'd0, 1'b0};
            4'd7:  t = '{2'd0, 2'd2, 1'b1};
            4'd8:  t = '{2'd3, 2'd2, 1'b0};
            4'd9:  t = '{2'd2, 2'd3, 1'b0};
            4'd10: t = '{2'd0, 2'd1, 1'b0};
            4'd11: t = '{2'd1, 2'd0, 1'b1};
            4'd12: t = '{2'd3, 2'd3, 1'b0};
            4'd13: t = '{2'd0, 2'd0, 1'b1};
            4'd14: t = '{2'd1, 2'd1, 1'b1};
            4'd15: t = '{2'd2, 2'd2, 1'b1};
            default: t = '{2'd0, 2'd0, 1'b0};
        endcase
        return t;
    endfunction

endpackage

FILE: src/qra_ctrl.sv
`timescale 1ns / 1ps
module qra_ctrl
    import qra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int MW = 34 - FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MAC    = 9'b000000010,
        S_SQR    = 9'b000000100,
        S_ROOT   = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_DLOAD  = 9'b000100000,
        S_DSTEP  = 9'b001000000,
        S_DSTORE = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       comp_reg, comp_next;
    logic             out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd.op         = OP_NOP;
        cmd.step       = cnt_reg[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.op   = OP_MAC;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(15))
                begin
                    cnt_next   = '0;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd.op   = OP_SQR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.op   = OP_ROOT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MW - 1))
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.op    = OP_DECIDE;
                comp_next = '0;
                state_next = stat.degen ? S_OUT : S_DLOAD;
            end
            S_DLOAD:
            begin
                cmd.op     = OP_DLOAD;
                cmd.step   = {2'b00, comp_reg};
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op   = OP_DSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = S_DSTORE;
            end
            S_DSTORE:
            begin
                cmd.op    = OP_DSTORE;
                cmd.step  = {2'b00, comp_reg};
                comp_next = comp_reg + 1'b1;
                state_next = (comp_reg == 2'd3) ? S_OUT : S_DLOAD;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MAC))
        else $error("accepted beat did not start the product");
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("commit without result beat");
    a_divcnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTEP) |-> (cnt_reg < CNT_W'(NUM_W)))
        else $error("divide counter overrun");

endmodule

FILE: src/qra_dp.sv
`timescale 1ns / 1ps
module qra_dp
    import qra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] rot_x,
    input  logic signed [DATA_W-1:0] rot_y,
    input  logic signed [DATA_W-1:0] rot_z,
    input  logic signed [DATA_W-1:0] rot_w,
    input  logic                     cfg_we,
    input  logic [LIMIT_W-1:0]       cfg_data,
    output logic signed [DATA_W-1:0] orient_x,
    output logic signed [DATA_W-1:0] orient_y,
    output logic signed [DATA_W-1:0] orient_z,
    output logic signed [DATA_W-1:0] orient_w,
    output logic                     degenerate
);

    localparam int MW = 34 - FRAC_BITS;   // product / magnitude width
    localparam int PW = MW;
    localparam int SW = 2 * MW;
    localparam int RW = MW + 2;
    localparam int CW = MW + LIMIT_W;
    localparam logic [ACC_W-1:0] RND = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [DATA_W-1:0] ONE_Q =
        (FRAC_BITS >= 15) ? 16'h7FFF : DATA_W'(64'd1 << FRAC_BITS);

    logic                     kind_reg;
    logic signed [DATA_W-1:0] rot_reg [4];
    logic signed [DATA_W-1:0] ori_reg [4];
    logic signed [DATA_W-1:0] newq_reg [4];
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic signed [PW-1:0]     prod_reg [4];
    logic [SW-1:0]            sumsq_reg;
    logic [RW-1:0]            rem_reg;
    logic [MW-1:0]            root_reg;
    logic                     degen_reg, out_degen_reg;
    logic [NUM_W-1:0]         num_reg, quot_reg;
    logic [MW-1:0]            drem_reg;
    logic                     dneg_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    term_t                    term;
    logic signed [DATA_W-1:0] a_vec [4];
    logic signed [DATA_W-1:0] b_vec [4];
    logic signed [2*DATA_W-1:0] mprod;
    logic signed [ACC_W-1:0]  acc_sel, acc_adj;
    logic signed [PW-1:0]     pt;
    logic signed [2*PW-1:0]   sq;
    logic [RW-1:0]            rem_sh, trial;
    logic [MW:0]              dr;
    logic signed [PW-1:0]     pd;
    logic [PW-1:0]            pabs;
    logic [DATA_W-1:0]        qclamp;
    logic                     degen_c;

    always_comb
    begin
        term = term_sel(cmd.step);
        for (int i = 0; i < 4; i++)
        begin
            a_vec[i] = kind_reg ? rot_reg[i] : ori_reg[i];
            b_vec[i] = kind_reg ? ori_reg[i] : rot_reg[i];
        end
        mprod   = a_vec[term.ai] * b_vec[term.bi];
        // truncate toward zero on the 2^F scale-down
        acc_sel = acc_reg[cmd.step[1:0]];
        acc_adj = acc_sel + (acc_sel[ACC_W-1] ? $signed(RND) : $signed(ACC_W'(0)));
        pt      = PW'(acc_adj >>> FRAC_BITS);
        sq      = pt * pt;
        rem_sh  = {rem_reg[RW-3:0], sumsq_reg[SW-1:SW-2]};
        trial   = {root_reg, 2'b01};
        dr      = {drem_reg, num_reg[NUM_W-1]};
        pd      = prod_reg[cmd.step[1:0]];
        pabs    = pd[PW-1] ? PW'(-pd) : PW'(pd);
        if (dneg_reg)
            qclamp = (quot_reg > NUM_W'(32768)) ? 16'h8000 : DATA_W'(~quot_reg + 1'b1);
        else
            qclamp = (quot_reg > NUM_W'(32767)) ? 16'h7FFF : quot_reg[DATA_W-1:0];
        degen_c = (root_reg == '0) || (CW'(root_reg) < CW'(limit_reg));
    end

    assign stat.degen = degen_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ori_reg[0] <= '0;
            ori_reg[1] <= '0;
            ori_reg[2] <= '0;
            ori_reg[3] <= ONE_Q;
            limit_reg  <= LIMIT_RST;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (cmd.op == OP_COMMIT)
                ori_reg <= newq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                kind_reg   <= kind;
                rot_reg[0] <= rot_x;
                rot_reg[1] <= rot_y;
                rot_reg[2] <= rot_z;
                rot_reg[3] <= rot_w;
                for (int i = 0; i < 4; i++)
                    acc_reg[i] <= '0;
                sumsq_reg <= '0;
                rem_reg   <= '0;
                root_reg  <= '0;
            end
            OP_MAC:
            begin
                if (term.neg)
                    acc_reg[cmd.step[3:2]] <= acc_reg[cmd.step[3:2]] - ACC_W'(mprod);
                else
                    acc_reg[cmd.step[3:2]] <= acc_reg[cmd.step[3:2]] + ACC_W'(mprod);
            end
            OP_SQR:
            begin
                prod_reg[cmd.step[1:0]] <= pt;
                sumsq_reg <= sumsq_reg + SW'(unsigned'(sq));
            end
            OP_ROOT:
            begin
                sumsq_reg <= sumsq_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[MW-2:0], 1'b0};
                end
            end
            OP_DECIDE:
            begin
                degen_reg <= degen_c;
                if (degen_c)
                begin
                    newq_reg[0] <= '0;
                    newq_reg[1] <= '0;
                    newq_reg[2] <= '0;
                    newq_reg[3] <= ONE_Q;
                end
            end
            OP_DLOAD:
            begin
                num_reg  <= NUM_W'(pabs) << FRAC_BITS;
                dneg_reg <= pd[PW-1];
                drem_reg <= '0;
                quot_reg <= '0;
            end
            OP_DSTEP:
            begin
                num_reg <= num_reg << 1;
                if (dr >= {1'b0, root_reg})
                begin
                    drem_reg <= MW'(dr - {1'b0, root_reg});
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dr[MW-1:0];
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
                end
            end
            OP_DSTORE:
            begin
                newq_reg[cmd.step[1:0]] <= qclamp;
            end
            OP_COMMIT:
            begin
                out_degen_reg <= degen_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign orient_x   = ori_reg[0];
    assign orient_y   = ori_reg[1];
    assign orient_z   = ori_reg[2];
    assign orient_w   = ori_reg[3];
    assign degenerate = out_degen_reg;

endmodule

FILE: src/quaternion_rotation_accumulator_core.sv
`timescale 1ns / 1ps
// Quaternion orientation accumulator. Holds an orientation (x, y, z, w, signed
// fixed point with FRAC_BITS fraction bits, identity after reset) and takes one
// rotation quaternion per beat: kind 0 multiplies orientation*rot, kind 1
// rot*orientation. The product is renormalized by its floored magnitude and
// becomes the new orientation, which is also the result beat; if the magnitude
// is zero or below degenerate_limit the identity is used and degenerate is set.
// A beat runs through accept, multiply-accumulate (single 16x16 multiplier),
// squaring, bit-serial square root, a decision and bit-serial division of
// each of the four components, then commit; the division is skipped when the
// identity is substituted. A new beat is taken as soon as the previous result
// is committed to the output register, even while that result still stalls.
// degenerate_limit is written through cfg_valid/cfg_data (always ready) and
// must only change while the block is idle.
module quaternion_rotation_accumulator_core
    import qra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] rot_x,
    input  logic signed [DATA_W-1:0] rot_y,
    input  logic signed [DATA_W-1:0] rot_z,
    input  logic signed [DATA_W-1:0] rot_w,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] orient_x,
    output logic signed [DATA_W-1:0] orient_y,
    output logic signed [DATA_W-1:0] orient_z,
    output logic signed [DATA_W-1:0] orient_w,
    output logic                     degenerate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIMIT_W-1:0]       cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    qra_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    qra_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .rot_x      (rot_x),
        .rot_y      (rot_y),
        .rot_z      (rot_z),
        .rot_w      (rot_w),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .orient_x   (orient_x),
        .orient_y   (orient_y),
        .orient_z   (orient_z),
        .orient_w   (orient_w),
        .degenerate (degenerate)
    );

endmodule
